FILE: hdl/dptp_pkg.sv
// Package with shared types and codes for the timer pool.
`default_nettype none
package dptp_pkg;

  typedef enum logic [2:0] {
    EV_CREATED = 3'd0,
    EV_FIRE    = 3'd1,
    EV_ENDED   = 3'd2,
    EV_ERROR   = 3'd3,
    EV_TICK    = 3'd4
  } ev_kind_t;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_CREATE = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;

  localparam logic [1:0] PH_FREE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_DELAY = 2'd2;
  localparam logic [1:0] PH_RUN   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  slot_index;
    logic [31:0] delay_ticks;
    logic [31:0] run_ticks;
    logic [31:0] period_ticks;
    logic        fire_enable;
    logic        end_enable;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [3:0] event_slot;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DONE
  } bk_state_t;

endpackage
`default_nettype wire

FILE: hdl/delayed_periodic_timer_pool.sv
// Timer pool top level: front register, request queue and slot engine.
// Create and stop pass the front register and the queue, and their event is registered
// in the output buffer. A tick walks the slots one per cycle through the slot RAM read port
// while no event waits in the output buffer, then emits a tick event.
// Throughput is one request at a time in the back part; the queue buffers two.
// Synchronous active-low reset frees all slots and clears the tick counter.
`default_nettype none
module delayed_periodic_timer_pool #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire dptp_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dptp_pkg::out_item_t       out_data
);
  import dptp_pkg::*;

  logic     fq_valid, fq_ready, qb_valid, qb_ready;
  in_item_t fq_data, qb_data;

  dptp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  dptp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(fq_valid), .wr_ready(fq_ready),
    .wr_data(fq_data), .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  dptp_back #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .req_valid(qb_valid), .req_ready(qb_ready),
    .req(qb_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire

FILE: hdl/dptp_ram.sv
// Generic single-port-write RAM with one registered read port.
`default_nettype none
module dptp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/dptp_fifo.sv
// Two-entry request queue between the front and back parts.
`default_nettype none
module dptp_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_valid,
  output logic                     wr_ready,
  input  wire dptp_pkg::in_item_t  wr_data,
  output logic                     rd_valid,
  input  wire logic                rd_ready,
  output dptp_pkg::in_item_t       rd_data
);
  import dptp_pkg::*;

  in_item_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_go, rd_go;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_go    = wr_valid && wr_ready;
  assign rd_go    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_go) begin
        wp_r <= ~wp_r;
      end
      if (rd_go) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr_go} - {1'b0, rd_go};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem_r[wp_r] <= wr_data;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/dptp_back.sv
// Back part: executes requests against the slot state and emits events.
`default_nettype none
module dptp_back #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire dptp_pkg::in_item_t req,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dptp_pkg::out_item_t     out_data
);
  import dptp_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int PW = 2 * TIME_BITS + 96 + 2;

  typedef struct packed {
    logic [TIME_BITS-1:0] stamp;
    logic [TIME_BITS-1:0] last;
    logic [31:0]          dly;
    logic [31:0]          run;
    logic [31:0]          per;
    logic [1:0]           flags;
  } slot_rec_t;

  bk_state_t            st_r, st_nxt;
  logic [1:0]           phase_r [SLOTS];
  logic [SW-1:0]        stack_r [SLOTS];
  logic [CW-1:0]        cnt_r;
  logic [TIME_BITS-1:0] now_r;
  logic [SW-1:0]        idx_r;
  logic                 rd_ok_r;
  logic                 obuf_v_r;
  out_item_t            obuf_r;

  logic          we;
  logic [SW-1:0] waddr, raddr;
  slot_rec_t     wrec, rrec;

  dptp_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wrec), .raddr(raddr), .rdata(rrec)
  );

  logic                 emit;
  out_item_t            ev;
  logic                 do_free;
  logic [SW-1:0]        free_s;
  logic [1:0]           ph_new;
  logic                 ph_we;
  logic [SW-1:0]        ph_s;
  logic                 pop;
  logic [SW-1:0]        top_s;
  logic [TIME_BITS-1:0] dst, dlf;
  logic                 stop_ok;
  logic [3:0]           stop_s4;
  logic                 last_slot;
  logic [1:0]           flag_sh_r [SLOTS];
  logic                 flags_of_stop;

  assign out_valid = obuf_v_r;
  assign out_data  = obuf_r;
  assign top_s     = stack_r[cnt_r[SW-1:0] - SW'(1)];
  assign stop_s4   = req.slot_index;
  assign stop_ok   = (32'(stop_s4) < SLOTS) && (phase_r[stop_s4[SW-1:0]] != PH_FREE);
  assign dst       = now_r - rrec.stamp;
  assign dlf       = now_r - rrec.last;
  assign last_slot = (32'(idx_r) == SLOTS - 1);

  // The RAM read address runs ahead of the walk position, so the next slot's record is read while the walk advances.
  always_comb begin
    raddr = idx_r;
    if (st_r == BK_IDLE) begin
      raddr = '0;
    end else if (st_r == BK_WALK && rd_ok_r && !obuf_v_r && !last_slot) begin
      raddr = idx_r + SW'(1);
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (req_valid && !obuf_v_r && req.cmd == CMD_TICK) st_nxt = BK_WALK;
      BK_WALK: if (rd_ok_r && !obuf_v_r && last_slot) st_nxt = BK_DONE;
      BK_DONE: if (!obuf_v_r) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    emit = 1'b0;
    ev = '0;
    do_free = 1'b0;
    free_s = '0;
    ph_we = 1'b0;
    ph_s = '0;
    ph_new = PH_FREE;
    pop = 1'b0;
    we = 1'b0;
    waddr = idx_r;
    wrec = rrec;
    unique case (st_r)
      BK_IDLE: begin
        if (req_valid && !obuf_v_r) begin
          req_ready = (req.cmd != CMD_TICK);
          case (req.cmd)
            CMD_CREATE: begin
              emit = 1'b1;
              ev.last_of_run = 1'b1;
              if (cnt_r == '0) begin
                ev.event_kind = EV_ERROR;
              end else begin
                pop = 1'b1;
                ev.event_kind = EV_CREATED;
                ev.event_slot = 4'(top_s);
                ph_we = 1'b1;
                ph_s = top_s;
                ph_new = PH_START;
                we = 1'b1;
                waddr = top_s;
                wrec.stamp = '0;
                wrec.last = '0;
                wrec.dly = req.delay_ticks;
                wrec.run = req.run_ticks;
                wrec.per = req.period_ticks;
                wrec.flags = {req.end_enable, req.fire_enable};
              end
            end
            CMD_STOP: begin
              ev.event_slot = stop_s4;
              ev.last_of_run = 1'b1;
              if (!stop_ok) begin
                emit = 1'b1;
                ev.event_kind = EV_ERROR;
              end else begin
                emit = phase_r[stop_s4[SW-1:0]] != PH_FREE && flags_of_stop;
                ev.event_kind = EV_ENDED;
                do_free = 1'b1;
                free_s = stop_s4[SW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      BK_WALK: begin
        if (rd_ok_r && !obuf_v_r) begin
          ev.event_slot = 4'(idx_r);
          unique case (phase_r[idx_r])
            PH_START: begin
              ph_we = 1'b1; ph_s = idx_r; ph_new = PH_DELAY;
              we = 1'b1; wrec.stamp = now_r;
            end
            PH_DELAY: begin
              if (rrec.dly == 32'd0 || {{(64-TIME_BITS){1'b0}}, dst} >= 64'(rrec.dly)) begin
                ph_we = 1'b1; ph_s = idx_r; ph_new = PH_RUN;
                we = 1'b1; wrec.stamp = now_r; wrec.last = now_r;
              end
            end
            PH_RUN: begin
              if (rrec.run != 32'd0 &&
                  {{(64-TIME_BITS){1'b0}}, dst} > 64'(rrec.run)) begin
                emit = rrec.flags[1];
                ev.event_kind = EV_ENDED;
                do_free = 1'b1;
                free_s = idx_r;
              end else if (rrec.flags[0]) begin
                if (rrec.per == 32'd0) begin
                  emit = 1'b1;
                  ev.event_kind = EV_FIRE;
                end else if ({{(64-TIME_BITS){1'b0}}, dlf} >= 64'(rrec.per)) begin
                  emit = 1'b1;
                  ev.event_kind = EV_FIRE;
                  we = 1'b1; wrec.last = now_r;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_DONE: begin
        if (!obuf_v_r) begin
          req_ready = 1'b1;
          emit = 1'b1;
          ev.event_kind = EV_TICK;
          ev.last_of_run = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Stop looks up the end flag; read it from a small flag shadow.
  assign flags_of_stop = flag_sh_r[stop_s4[SW-1:0]][1];

  always_ff @(posedge clk) begin
    if (we) begin
      flag_sh_r[waddr] <= wrec.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= BK_IDLE;
      cnt_r    <= CW'(SLOTS);
      now_r    <= '0;
      idx_r    <= '0;
      rd_ok_r  <= 1'b0;
      obuf_v_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        phase_r[i] <= PH_FREE;
        stack_r[i] <= SW'(SLOTS - 1 - i);
      end
    end else begin
      st_r <= st_nxt;
      if (emit) begin
        obuf_v_r <= 1'b1;
      end else if (out_ready) begin
        obuf_v_r <= 1'b0;
      end
      if (ph_we) begin
        phase_r[ph_s] <= ph_new;
      end
      if (do_free) begin
        phase_r[free_s] <= PH_FREE;
        stack_r[cnt_r[SW-1:0]] <= free_s;
        cnt_r <= cnt_r + CW'(1);
      end
      if (pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (st_r == BK_IDLE) begin
        idx_r   <= '0;
        rd_ok_r <= 1'b0;
        if (st_nxt == BK_WALK) begin
          now_r   <= now_r + TIME_BITS'(1);
          rd_ok_r <= 1'b1;
        end
      end else if (st_r == BK_WALK) begin
        // A write to the slot just visited invalidates nothing ahead of it.
        if (rd_ok_r && !obuf_v_r) begin
          if (!last_slot) begin
            idx_r <= idx_r + SW'(1);
          end
          rd_ok_r <= 1'b1;
        end else if (!rd_ok_r) begin
          rd_ok_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obuf_r <= ev;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/dptp_front.sv
// Front part: input register that accepts requests, drops unused command codes and feeds the queue.
`default_nettype none
module dptp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dptp_pkg::in_item_t in_data,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output dptp_pkg::in_item_t      q_data
);
  import dptp_pkg::*;

  logic     v_r;
  in_item_t d_r;

  // Unused command codes are dropped here and never reach the back part.
  assign in_ready = !v_r || q_ready;
  assign q_valid  = v_r;
  assign q_data   = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid && (in_data.cmd == CMD_TICK || in_data.cmd == CMD_CREATE ||
                          in_data.cmd == CMD_STOP);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      d_r <= in_data;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/dptp_checker.sv
// Port-level checker for the timer pool, bound to the top level.
`default_nettype none
module dptp_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire dptp_pkg::out_item_t out_data
);
  import dptp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("request withdrawn while stalled");

  a_tick_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == EV_TICK |->
      out_data.last_of_run && out_data.event_slot == 4'd0)
    else $error("tick done not last");

  a_fire_notlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == EV_FIRE |-> !out_data.last_of_run)
    else $error("fire marked last");

  a_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");
endmodule

bind delayed_periodic_timer_pool dptp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
